@@ sv/pwmseq_pkg.sv @@
// Shared types and constants for the two-channel PWM duty sequencer.
// No dependencies; pwmseq_scale and the sequencer core use it.
`default_nettype none

package pwmseq_pkg;

  localparam int MAX_ENTRIES_DEF = 128;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int TIME_W     = 32;
  localparam int DUTY_IN_W  = 16;
  localparam int DUTY_W     = 13;
  localparam int WRAP_W     = 16;
  localparam int LEVEL_W    = 16;
  localparam int STEP_OUT_W = 7;
  localparam int CNT_OUT_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int Q_SHIFT    = 12;
  localparam int PROD_W     = DUTY_W + WRAP_W;

  // Q12 full scale
  localparam logic [DUTY_IN_W-1:0] FULL_SCALE_IN = 16'd4096;
  localparam logic [DUTY_W-1:0]    FULL_SCALE    = 13'd4096;

  // Reset values of the configuration registers and levels
  localparam logic [WRAP_W-1:0]  WRAP_RESET  = 16'd2499;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd2499;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_WRAP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_TRIG   = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_POLL   = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_APPEND = 2'd2,
    KIND_COMMIT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADVANCE,
    ST_REM_GO,
    ST_REM_WAIT,
    ST_READ,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ sv/pwmseq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pwmseq_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/pwmseq_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module pwmseq_rem #(
  parameter int DIV_W = 7,
  parameter int DVS_W = 8,
  localparam int ITER_W = $clog2(DIV_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic      [DIV_W-1:0] remainder
);

  logic [DVS_W-1:0]  acc;
  logic [DIV_W-1:0]  shreg;
  logic [ITER_W-1:0] iter;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic [DVS_W-1:0]  acc_next;

  always_comb begin
    trial = {acc, shreg[DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      acc_next = diff[DVS_W-1:0];
    end else begin
      acc_next = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= ITER_W'(DIV_W);
    end else if (busy) begin
      iter <= iter - 1'b1;
      if (iter == ITER_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      acc   <= acc_next;
      shreg <= shreg << 1;
    end
  end

  // remainder < divisor <= depth, so the low bits carry it
  assign remainder = acc[DIV_W-1:0];

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && divisor != '0 |-> acc < divisor)
    else $error("remainder not below divisor");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("remainder unit did not start");

endmodule

`default_nettype wire

@@ sv/pwmseq_scale.sv @@
// Duty to compare level: optional inversion, then a registered multiply by wrap.
// Depends on pwmseq_pkg.
`default_nettype none

module pwmseq_scale (
  input  wire logic                               clk,
  input  wire logic [pwmseq_pkg::DUTY_W-1:0]      duty,
  input  wire logic [pwmseq_pkg::WRAP_W-1:0]      wrap,
  input  wire logic                               invert,
  output logic      [pwmseq_pkg::LEVEL_W-1:0]     level
);

  logic [pwmseq_pkg::DUTY_W-1:0] duty_sel;
  logic [pwmseq_pkg::PROD_W-1:0] prod;

  always_comb begin
    if (invert) begin
      duty_sel = pwmseq_pkg::FULL_SCALE - duty;
    end else begin
      duty_sel = duty;
    end
  end

  always_ff @(posedge clk) begin
    prod <= pwmseq_pkg::PROD_W'(duty_sel) * pwmseq_pkg::PROD_W'(wrap);
  end

  // floor(d * wrap / 4096)
  assign level = prod[pwmseq_pkg::Q_SHIFT +: pwmseq_pkg::LEVEL_W];

endmodule

`default_nettype wire

@@ sv/two_channel_pwm_duty_sequencer_core.sv @@
// Two-channel PWM duty sequencer: duty tables live in two RAMs, a poll item
// gates the sequence on the trigger and steps it once the step duration in
// milliseconds has elapsed, and every item returns one status transaction.
// Items are handled one at a time. Load, append and commit items pass from
// execute to done; polls also pass the advance state. A poll while running
// with a nonzero step duration refreshes the levels: the step, ADDR_W bits
// wide (clog2(MAX_ENTRIES) but at least 1), is reduced modulo each channel
// count by a bit-serial remainder unit, one step bit per cycle, then the RAMs
// are read and the duties scaled by one registered multiply. A finished
// transaction waits in the output register while the next item is taken in;
// the block holds in its done state only if a second result completes before
// the first is taken. No clearing pass is needed after reset.
`default_nettype none

module two_channel_pwm_duty_sequencer_core #(
  parameter int MAX_ENTRIES = pwmseq_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // item channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [pwmseq_pkg::KIND_W-1:0]         kind,
  input  wire logic                                  hw_trig,
  input  wire logic [pwmseq_pkg::TIME_W-1:0]         now_ms,
  input  wire logic [pwmseq_pkg::DUTY_IN_W-1:0]      duty_ch1,
  input  wire logic [pwmseq_pkg::DUTY_IN_W-1:0]      duty_ch2,
  input  wire logic                                  has_ch1,
  input  wire logic                                  has_ch2,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic      [pwmseq_pkg::LEVEL_W-1:0]        level_ch1,
  output logic      [pwmseq_pkg::LEVEL_W-1:0]        level_ch2,
  output logic                                       running,
  output logic      [pwmseq_pkg::STEP_OUT_W-1:0]     step_index,
  output logic      [pwmseq_pkg::CNT_OUT_W-1:0]      count_ch1,
  output logic      [pwmseq_pkg::CNT_OUT_W-1:0]      count_ch2,
  output logic                                       seq_enabled,
  output logic                                       loading,
  // configuration write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [pwmseq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pwmseq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  // configuration registers
  logic [pwmseq_pkg::TIME_W-1:0] step_dur;
  logic [pwmseq_pkg::WRAP_W-1:0] pwm_wrap;
  logic                          invert;
  logic                          manual_mode;
  logic                          manual_trig;

  // accepted item
  pwmseq_pkg::kind_t                  kind_q;
  logic                               pin_q;
  logic [pwmseq_pkg::TIME_W-1:0]      now_q;
  logic [pwmseq_pkg::DUTY_IN_W-1:0]   duty1_q;
  logic [pwmseq_pkg::DUTY_IN_W-1:0]   duty2_q;
  logic                               has1_q;
  logic                               has2_q;

  // sequencer state
  pwmseq_pkg::state_t            state;
  pwmseq_pkg::state_t            state_next;
  logic [CNT_W-1:0]              cnt1;
  logic [CNT_W-1:0]              cnt2;
  logic [ADDR_W-1:0]             step;
  logic [pwmseq_pkg::TIME_W-1:0] start_ms;
  logic                          run;
  logic                          enable;
  logic                          load;
  logic                          elapsed;
  logic [pwmseq_pkg::LEVEL_W-1:0] lvl1;
  logic [pwmseq_pkg::LEVEL_W-1:0] lvl2;

  // datapath
  logic                            trig;
  logic                            do_start;
  logic                            do_stop;
  logic [pwmseq_pkg::TIME_W-1:0]   since;
  logic [CNT_W-1:0]                top;
  logic [CNT_W-1:0]                step_inc;
  logic                            advancing;
  logic                            we1;
  logic                            we2;
  logic                            rem_start;
  logic                            rem_busy1;
  logic                            rem_busy2;
  logic [ADDR_W-1:0]               rem1;
  logic [ADDR_W-1:0]               rem2;
  logic [pwmseq_pkg::DUTY_W-1:0]   rdata1;
  logic [pwmseq_pkg::DUTY_W-1:0]   rdata2;
  logic [pwmseq_pkg::LEVEL_W-1:0]  scaled1;
  logic [pwmseq_pkg::LEVEL_W-1:0]  scaled2;
  logic                            out_load;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_dur    <= '0;
      pwm_wrap    <= pwmseq_pkg::WRAP_RESET;
      invert      <= 1'b1;
      manual_mode <= 1'b0;
      manual_trig <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwmseq_pkg::CFG_STEP_DURATION: step_dur    <= cfg_data;
        pwmseq_pkg::CFG_PWM_WRAP:      pwm_wrap    <= cfg_data[pwmseq_pkg::WRAP_W-1:0];
        pwmseq_pkg::CFG_INVERT:        invert      <= cfg_data[0];
        pwmseq_pkg::CFG_MANUAL_MODE:   manual_mode <= cfg_data[0];
        pwmseq_pkg::CFG_MANUAL_TRIG:   manual_trig <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_q  <= pwmseq_pkg::kind_t'(kind);
      pin_q   <= hw_trig;
      now_q   <= now_ms;
      duty1_q <= duty_ch1;
      duty2_q <= duty_ch2;
      has1_q  <= has_ch1;
      has2_q  <= has_ch2;
    end
  end

  // trigger gate and step arithmetic
  always_comb begin
    trig      = manual_mode ? manual_trig : pin_q;
    do_start  = trig && enable && !run;
    do_stop   = !trig && run;
    since     = now_q - start_ms;
    top       = (cnt1 > cnt2) ? cnt1 : cnt2;
    step_inc  = CNT_W'(step) + CNT_W'(elapsed);
    advancing = run && (step_dur != '0);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pwmseq_pkg::ST_IDLE: begin
        if (in_valid) state_next = pwmseq_pkg::ST_EXEC;
      end
      pwmseq_pkg::ST_EXEC: begin
        if (kind_q == pwmseq_pkg::KIND_POLL) state_next = pwmseq_pkg::ST_ADVANCE;
        else state_next = pwmseq_pkg::ST_DONE;
      end
      pwmseq_pkg::ST_ADVANCE: begin
        if (advancing) state_next = pwmseq_pkg::ST_REM_GO;
        else state_next = pwmseq_pkg::ST_DONE;
      end
      pwmseq_pkg::ST_REM_GO:   state_next = pwmseq_pkg::ST_REM_WAIT;
      pwmseq_pkg::ST_REM_WAIT: begin
        if (!rem_busy1 && !rem_busy2) state_next = pwmseq_pkg::ST_READ;
      end
      pwmseq_pkg::ST_READ:     state_next = pwmseq_pkg::ST_MUL;
      pwmseq_pkg::ST_MUL:      state_next = pwmseq_pkg::ST_DONE;
      pwmseq_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = pwmseq_pkg::ST_IDLE;
      end
      default: state_next = pwmseq_pkg::ST_IDLE;
    endcase
  end

  // state decodes
  always_comb begin
    in_stall  = 1'b1;
    rem_start = 1'b0;
    we1       = 1'b0;
    we2       = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      pwmseq_pkg::ST_IDLE:   in_stall  = rst;
      pwmseq_pkg::ST_REM_GO: rem_start = 1'b1;
      pwmseq_pkg::ST_EXEC: begin
        if (kind_q == pwmseq_pkg::KIND_APPEND && load) begin
          we1 = has1_q && (duty1_q <= pwmseq_pkg::FULL_SCALE_IN)
                && (cnt1 < CNT_W'(MAX_ENTRIES));
          we2 = has2_q && (duty2_q <= pwmseq_pkg::FULL_SCALE_IN)
                && (cnt2 < CNT_W'(MAX_ENTRIES));
        end
      end
      pwmseq_pkg::ST_DONE:   out_load  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pwmseq_pkg::ST_IDLE;
      cnt1     <= '0;
      cnt2     <= '0;
      step     <= '0;
      start_ms <= '0;
      run      <= 1'b0;
      enable   <= 1'b0;
      load     <= 1'b0;
      elapsed  <= 1'b0;
      lvl1     <= pwmseq_pkg::LEVEL_RESET;
      lvl2     <= pwmseq_pkg::LEVEL_RESET;
    end else begin
      state <= state_next;
      unique case (state)
        pwmseq_pkg::ST_EXEC: begin
          unique case (kind_q)
            pwmseq_pkg::KIND_POLL: begin
              // a fresh start has zero elapsed time
              elapsed <= !do_start && (since >= step_dur);
              if (do_start) begin
                run      <= 1'b1;
                start_ms <= now_q;
                step     <= '0;
              end else if (do_stop) begin
                run  <= 1'b0;
                lvl1 <= '0;
                lvl2 <= '0;
                step <= '0;
              end
            end
            pwmseq_pkg::KIND_LOAD: begin
              cnt1 <= '0;
              cnt2 <= '0;
              load <= 1'b1;
            end
            pwmseq_pkg::KIND_APPEND: begin
              if (we1) cnt1 <= cnt1 + 1'b1;
              if (we2) cnt2 <= cnt2 + 1'b1;
            end
            pwmseq_pkg::KIND_COMMIT: begin
              load   <= 1'b0;
              enable <= (cnt1 != '0) || (cnt2 != '0);
            end
            default: ;
          endcase
        end
        pwmseq_pkg::ST_ADVANCE: begin
          if (advancing) begin
            if (elapsed) start_ms <= now_q;
            // wrap at the longer table, hold at zero when both are empty
            if (top == '0 || step_inc >= top) step <= '0;
            else step <= step_inc[ADDR_W-1:0];
          end
        end
        pwmseq_pkg::ST_MUL: begin
          lvl1 <= (cnt1 == '0) ? '0 : scaled1;
          lvl2 <= (cnt2 == '0) ? '0 : scaled2;
        end
        default: ;
      endcase
    end
  end

  pwmseq_ram #(
    .WIDTH(pwmseq_pkg::DUTY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram_ch1 (
    .clk  (clk),
    .we   (we1),
    .waddr(cnt1[ADDR_W-1:0]),
    .wdata(duty1_q[pwmseq_pkg::DUTY_W-1:0]),
    .raddr(rem1),
    .rdata(rdata1)
  );

  pwmseq_ram #(
    .WIDTH(pwmseq_pkg::DUTY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram_ch2 (
    .clk  (clk),
    .we   (we2),
    .waddr(cnt2[ADDR_W-1:0]),
    .wdata(duty2_q[pwmseq_pkg::DUTY_W-1:0]),
    .raddr(rem2),
    .rdata(rdata2)
  );

  pwmseq_rem #(
    .DIV_W(ADDR_W),
    .DVS_W(CNT_W)
  ) u_rem_ch1 (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (step),
    .divisor  (cnt1),
    .busy     (rem_busy1),
    .remainder(rem1)
  );

  pwmseq_rem #(
    .DIV_W(ADDR_W),
    .DVS_W(CNT_W)
  ) u_rem_ch2 (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (step),
    .divisor  (cnt2),
    .busy     (rem_busy2),
    .remainder(rem2)
  );

  pwmseq_scale u_scale_ch1 (
    .clk   (clk),
    .duty  (rdata1),
    .wrap  (pwm_wrap),
    .invert(invert),
    .level (scaled1)
  );

  pwmseq_scale u_scale_ch2 (
    .clk   (clk),
    .duty  (rdata2),
    .wrap  (pwm_wrap),
    .invert(invert),
    .level (scaled2)
  );

  // output register: holds a finished transaction while the next item runs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level_ch1   <= lvl1;
      level_ch2   <= lvl2;
      running     <= run;
      step_index  <= pwmseq_pkg::STEP_OUT_W'(step);
      count_ch1   <= pwmseq_pkg::CNT_OUT_W'(cnt1);
      count_ch2   <= pwmseq_pkg::CNT_OUT_W'(cnt2);
      seq_enabled <= enable;
      loading     <= load;
    end
  end

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == pwmseq_pkg::ST_EXEC)
    else $error("accepted item not executed");

  a_done_publishes: assert property (@(posedge clk) disable iff (rst)
    state == pwmseq_pkg::ST_DONE && !(out_valid && out_stall) |=> out_valid)
    else $error("finished item not published");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    state == pwmseq_pkg::ST_ADVANCE && advancing
    |=> step == '0 || CNT_W'(step) < top)
    else $error("step beyond longest table");

  a_empty_channel_zero: assert property (@(posedge clk) disable iff (rst)
    state == pwmseq_pkg::ST_MUL && cnt1 == '0 |=> lvl1 == '0)
    else $error("empty channel drives nonzero level");

endmodule

`default_nettype wire
